>>> rtl/sparse_iir_filter_assert.svh
// assertion macros shared by the sparse iir filter rtl
// expects clk and arst_n in the scope of the including module
`ifndef SPARSE_IIR_FILTER_ASSERT_SVH
`define SPARSE_IIR_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SIF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SIF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sif_pkg.sv
// shared types and constants of the sparse iir filter
// no dependencies
package sif_pkg;

	// coefficient format: signed q2.14
	localparam int COEF_W = 16;
	localparam int FRAC_W = 14;
	localparam int ROUND_BIAS = 8192;

	// register file layout: three feed-forward taps, then five feedback taps
	localparam int NUM_X = 3;
	localparam int NUM_Y = 5;
	localparam int NUM_COEFS = NUM_X + NUM_Y;
	localparam int CFG_IDX_W = $clog2(NUM_COEFS);

	// delay line depths
	localparam int IN_DEPTH = 9;
	localparam int OUT_DEPTH = 10;

	typedef logic signed [COEF_W-1:0] coef_t;

	// history positions read for the current sample (position 0 is one sample back)
	localparam int X_TAP [NUM_X] = '{4, 6, 8};
	localparam int Y_TAP [NUM_Y] = '{1, 3, 5, 7, 9};

	// coefficient values after reset, in register index order
	localparam coef_t COEF_RESET [NUM_COEFS] = '{
		16'sd16384, -16'sd9994, 16'sd1475, 16'sd7373,
		16'sd4157, -16'sd5014, -16'sd4206, -16'sd336
	};

endpackage

>>> rtl/sparse_iir_filter.sv
// the result of a sample transaction is pushed into the output buffer and offered from its register
// throughput: one sample per cycle while the buffer has room, set by the product register stage feeding the adder tree
// a coefficient write holds off input for the following cycle while the products reload
// reset: delay lines, products and output buffer clear; coefficients load q2.14 defaults
// depends on sif_pkg, sif_mul, sif_sum, sif_skid and sparse_iir_filter_assert.svh
`include "sparse_iir_filter_assert.svh"

module sparse_iir_filter import sif_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           saturated,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [COEF_W-1:0]              cfg_wdata
);

	localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	coef_t                          coef_q [NUM_COEFS];
	logic                           cfg_hold_q;
	logic signed [SAMPLE_WIDTH-1:0] in_hist_q [IN_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] out_hist_q [OUT_DEPTH];
	logic signed [PROD_W-1:0]       prod_q [NUM_COEFS];
	logic signed [SAMPLE_WIDTH-1:0] y;
	logic                           clip;
	logic                           accept;
	logic                           skid_ready;
	logic [SAMPLE_WIDTH:0]          out_data;
	logic                           at_limit;

	assign accept = in_valid && in_ready;
	assign in_ready = skid_ready && !cfg_hold_q;

	// coefficient registers and one-cycle reload hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
			cfg_hold_q <= 1'b0;
		end else begin
			cfg_hold_q <= cfg_we;
			if (cfg_we) begin
				coef_q[cfg_index] <= cfg_wdata;
			end
		end
	end

	// input and output delay lines shift on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IN_DEPTH; i++) begin
				in_hist_q[i] <= '0;
			end
			for (int i = 0; i < OUT_DEPTH; i++) begin
				out_hist_q[i] <= '0;
			end
		end else if (accept) begin
			in_hist_q[0] <= sample_in;
			for (int i = 1; i < IN_DEPTH; i++) begin
				in_hist_q[i] <= in_hist_q[i-1];
			end
			out_hist_q[0] <= y;
			for (int i = 1; i < OUT_DEPTH; i++) begin
				out_hist_q[i] <= out_hist_q[i-1];
			end
		end
	end

	// products for the next sample, prepared from the history it will see
	sif_mul #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.in_hist (in_hist_q),
		.out_hist(out_hist_q),
		.coefs   (coef_q),
		.prod_q  (prod_q)
	);

	// sum, round and saturate
	sif_sum #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_sum (
		.prod(prod_q),
		.y   (y),
		.clip(clip)
	);

	// result buffer toward the consumer
	sif_skid #(
		.WIDTH(SAMPLE_WIDTH + 1)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data ({clip, y}),
		.push_ready(skid_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign sample_out = out_data[SAMPLE_WIDTH-1:0];
	assign saturated = out_data[SAMPLE_WIDTH];

	// result sits at one of the range limits
	assign at_limit = (sample_out == SAMPLE_MAX) || (sample_out == SAMPLE_MIN);

	// checks
	`SIF_ASSERT_IMP(a_cfg_hold, cfg_hold_q, !in_ready, "sample taken while products reload")
	`SIF_ASSERT_NXT(a_accept_out, accept, out_valid, "transaction left no pending result")
	`SIF_ASSERT_IMP(a_sat_value, out_valid && saturated, at_limit, "clipped result off range limit")
	`SIF_ASSERT_NXT(a_hist_shift, accept, in_hist_q[1] == $past(in_hist_q[0]), "history not shifted")

endmodule

>>> rtl/sif_mul.sv
// product register stage: eight tap-by-coefficient products for the next sample
// depends on sif_pkg
module sif_mul import sif_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	localparam int PROD_W = SAMPLE_WIDTH + COEF_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic signed [SAMPLE_WIDTH-1:0] in_hist [IN_DEPTH],
	input  logic signed [SAMPLE_WIDTH-1:0] out_hist [OUT_DEPTH],
	input  coef_t                          coefs [NUM_COEFS],
	output logic signed [PROD_W-1:0]       prod_q [NUM_COEFS]
);

	logic signed [SAMPLE_WIDTH-1:0] tap [NUM_COEFS];

	// on a transaction the history shifts, so the next sample sees each tap one slot earlier
	always_comb begin
		for (int k = 0; k < NUM_X; k++) begin
			tap[k] = advance ? in_hist[X_TAP[k] - 1] : in_hist[X_TAP[k]];
		end
		for (int k = 0; k < NUM_Y; k++) begin
			tap[NUM_X + k] = advance ? out_hist[Y_TAP[k] - 1] : out_hist[Y_TAP[k]];
		end
	end

	// one multiplier per tap, registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				prod_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				prod_q[i] <= PROD_W'(tap[i]) * PROD_W'(coefs[i]);
			end
		end
	end

endmodule

>>> rtl/sif_sum.sv
// adder tree, rounding and saturation of the registered products
// depends on sif_pkg
module sif_sum import sif_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	localparam int PROD_W = SAMPLE_WIDTH + COEF_W
) (
	input  logic signed [PROD_W-1:0]       prod [NUM_COEFS],
	output logic signed [SAMPLE_WIDTH-1:0] y,
	output logic                           clip
);

	localparam int ACC_W = PROD_W + 4;
	localparam int HI_W = ACC_W - SAMPLE_WIDTH + 1;
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic signed [ACC_W-1:0] lvl1 [NUM_COEFS/2];
	logic signed [ACC_W-1:0] lvl2 [NUM_COEFS/4];
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] rounded;
	logic signed [ACC_W-1:0] shifted;
	logic        [HI_W-1:0]  hi;

	// three-level tree over the eight products
	always_comb begin
		for (int i = 0; i < NUM_COEFS/2; i++) begin
			lvl1[i] = ACC_W'(prod[2*i]) + ACC_W'(prod[2*i + 1]);
		end
		for (int i = 0; i < NUM_COEFS/4; i++) begin
			lvl2[i] = lvl1[2*i] + lvl1[2*i + 1];
		end
		acc = lvl2[0] + lvl2[1];
	end

	// round half up, then floor shift
	assign rounded = acc + ACC_W'(ROUND_BIAS);
	assign shifted = rounded >>> FRAC_W;

	// clip when the bits above the sample sign are not a pure sign extension
	assign hi = shifted[ACC_W-1:SAMPLE_WIDTH-1];

	always_comb begin
		clip = !((&hi) || !(|hi));
		if (!clip) begin
			y = shifted[SAMPLE_WIDTH-1:0];
		end else if (shifted[ACC_W-1]) begin
			y = SAMPLE_MIN;
		end else begin
			y = SAMPLE_MAX;
		end
	end

endmodule

>>> rtl/sif_skid.sv
// two-entry output buffer: output register plus skid register
// no dependencies
module sif_skid #(
	parameter int WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             main_valid_q;
	logic [WIDTH-1:0] main_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             pop;

	assign pop = main_valid_q && out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data = main_data_q;

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// payload, kept in transaction order
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_data_q <= push_data;
			end else begin
				main_data_q <= push_data;
			end
		end
	end

endmodule
